// ===== src/hjc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the hash-join count/probe core.
// No dependencies; imported by hjc_mix, the core and the testbench.
package hjc_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int DEPTH_W     = $clog2(TABLE_DEPTH + 1);

   localparam logic [63:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2   = 64'h94d049bb133111eb;
   localparam logic [63:0] GOLDEN64 = 64'h9e3779b97f4a7c15;
   localparam logic [31:0] GOLDEN32 = 32'h9E3779B1;
   localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

   localparam logic [1:0] OP_BUILD     = 2'd0;
   localparam logic [1:0] OP_PROBE     = 2'd1;
   localparam logic [1:0] OP_CLEAR     = 2'd2;
   localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] join_key;
   } req_type;

   typedef struct packed {
      logic [63:0] match_total;
      logic [63:0] checksum_a;
      logic [63:0] checksum_b;
      logic [31:0] multiplicity;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [31:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HOME,
      ST_READ,
      ST_CHECK,
      ST_MIX,
      ST_FINISH
   } state_type;

endpackage

// ===== src/hjc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module hjc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/hjc_mix.sv =====
`timescale 1ns / 1ps
// Checksum unit: splitmix64 of a key and of the key xor the golden constant,
// each times a count, on one shared 32x32 multiplier. Depends on hjc_pkg.
module hjc_mix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   input  logic [31:0] mult,
   output logic        busy,
   output logic        done,
   output logic [63:0] sum_a,
   output logic [63:0] sum_b
);
   import hjc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        lane_ff, lane_in;
   logic [1:0]  stage_ff, stage_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] key_ff, key_in;
   logic [31:0] mult_ff, mult_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] res_a_ff, res_a_in;
   logic [63:0] res_b_ff, res_b_in;

   logic [63:0] pre;
   logic [63:0] b_sel;
   logic [31:0] op_x, op_y;
   logic [63:0] prod;
   logic [63:0] product_done;

   always_comb begin
      unique case (stage_ff)
         2'd0:    pre = x_ff ^ (x_ff >> 30);
         2'd1:    pre = x_ff ^ (x_ff >> 27);
         default: pre = x_ff ^ (x_ff >> 31);
      endcase
      unique case (stage_ff)
         2'd0:    b_sel = MIX_C1;
         2'd1:    b_sel = MIX_C2;
         default: b_sel = {32'd0, mult_ff};
      endcase
      // The low 64 bits of a 64x64 product take three partial products.
      op_x = (phase_ff == 2'd3) ? a_ff[63:32] : a_ff[31:0];
      op_y = (phase_ff == 2'd2) ? b_ff[63:32] : b_ff[31:0];
      prod = {32'd0, op_x} * {32'd0, op_y};
      product_done = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      lane_in  = lane_ff;
      stage_in = stage_ff;
      phase_in = phase_ff;
      key_in   = key_ff;
      mult_in  = mult_ff;
      x_in     = x_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      res_a_in = res_a_ff;
      res_b_in = res_b_ff;
      if (start) begin
         busy_in  = 1'b1;
         key_in   = key;
         mult_in  = mult;
         x_in     = key + GOLDEN64;
         lane_in  = 1'b0;
         stage_in = 2'd0;
         phase_in = 2'd0;
      end else if (busy_ff) begin
         unique case (phase_ff)
            2'd0: begin
               a_in     = pre;
               b_in     = b_sel;
               phase_in = 2'd1;
            end
            2'd1: begin
               acc_in   = prod;
               phase_in = 2'd2;
            end
            2'd2: begin
               acc_in   = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
               phase_in = 2'd3;
            end
            default: begin
               phase_in = 2'd0;
               if (stage_ff == 2'd2) begin
                  stage_in = 2'd0;
                  if (!lane_ff) begin
                     res_a_in = product_done;
                     x_in     = (key_ff ^ GOLDEN64) + GOLDEN64;
                     lane_in  = 1'b1;
                  end else begin
                     res_b_in = product_done;
                     busy_in  = 1'b0;
                     done_in  = 1'b1;
                  end
               end else begin
                  x_in     = product_done;
                  stage_in = stage_ff + 2'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         lane_ff  <= 1'b0;
         stage_ff <= 2'd0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         lane_ff  <= lane_in;
         stage_ff <= stage_in;
         phase_ff <= phase_in;
      end
      key_ff   <= key_in;
      mult_ff  <= mult_in;
      x_ff     <= x_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      res_a_ff <= res_a_in;
      res_b_ff <= res_b_in;
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign sum_a = res_a_ff;
   assign sum_b = res_b_ff;

endmodule

// ===== src/hash_join_count_probe_core.sv =====
`timescale 1ns / 1ps
// Top level of the counting hash-join engine: request/response channels,
// slot search state machine and totals. Depends on hjc_pkg, hjc_ram, hjc_mix.
//
// Usage. Each request on the req_ channel carries an opcode and a 64-bit key:
// build inserts the key or bumps its count, probe looks the key up, and the
// two clear opcodes empty the table (the second also zeroes the totals).
// Every request yields exactly one response on the rsp_ channel with the
// running match total, both checksums, the count seen and a status code.
// Requests are handled one at a time. For a build or a probe the RAM read
// of the next table slot overlaps the check of the current one.
// A probe hit also runs the checksum unit: six 64-bit products of three
// partial products each on one 32x32 multiplier, after which it hands the
// sums over. req_ready returns in the same cycle as the new response
// appears on the rsp_ channel.
// A clear sweeps the table RAM one slot a cycle and then loads the response.
// After reset the same sweep runs with req_ready low.
// The response sits in an output register; while the receiver stalls the
// core still takes and works on the next request, and only holds it in its
// final state until the output register is free.
module hash_join_count_probe_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hjc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hjc_pkg::rsp_type rsp_payload
);
   import hjc_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [63:0]      key_ff, key_in;
   logic [31:0]      hash_ff, hash_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      mult_ff, mult_in;
   logic [1:0]       stat_ff, stat_in;
   logic             with_rsp_ff, with_rsp_in;
   logic [63:0]      match_ff, match_in;
   logic [63:0]      suma_ff, suma_in;
   logic [63:0]      sumb_ff, sumb_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_addr;
   entry_type          ram_wdata;
   logic [ENTRY_W-1:0] ram_rbits;
   entry_type          rd;

   logic        mix_start, mix_busy, mix_done;
   logic [63:0] mix_a, mix_b;

   logic [31:0]          folded;
   logic [63:0]          hash_prod;
   logic [32+DEPTH_W-1:0] home_prod;
   logic [IDX_W-1:0]     idx_next;

   hjc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rbits)
   );

   // The count is taken straight from the entry read, as the unit latches it
   // at the start cycle.
   hjc_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (key_ff),
      .mult  (rd.count),
      .busy  (mix_busy),
      .done  (mix_done),
      .sum_a (mix_a),
      .sum_b (mix_b)
   );

   assign rd = entry_type'(ram_rbits);

   // Home slot: fold the key, multiply by the 32-bit golden ratio, then scale
   // the hash onto the table. Each multiply has a state of its own (ST_HASH, ST_HOME).
   assign folded    = key_ff[31:0] ^ key_ff[63:32];
   assign hash_prod = {32'd0, folded} * {32'd0, GOLDEN32};
   assign home_prod = {{DEPTH_W{1'b0}}, hash_ff} * (32 + DEPTH_W)'(TABLE_DEPTH);
   assign idx_next  = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      hash_in      = hash_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      mult_in      = mult_ff;
      stat_in      = stat_ff;
      with_rsp_in  = with_rsp_ff;
      match_in     = match_ff;
      suma_in      = suma_ff;
      sumb_in      = sumb_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_addr     = idx_ff;
      ram_wdata    = '{valid: 1'b1, key: key_ff, count: 32'd1};
      mix_start    = 1'b0;
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            // One slot a cycle is written to all zeros: marked empty, key and count cleared.
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (idx_ff == LAST_IDX) begin
               state_in = with_rsp_ff ? ST_FINISH : ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_payload.opcode;
               key_in  = req_payload.join_key;
               mult_in = 32'd0;
               stat_in = STAT_OK;
               if (req_payload.opcode == OP_CLEAR ||
                   req_payload.opcode == OP_CLEAR_ALL) begin
                  idx_in      = '0;
                  with_rsp_in = 1'b1;
                  state_in    = ST_CLEAR;
                  if (req_payload.opcode == OP_CLEAR_ALL) begin
                     match_in = '0;
                     suma_in  = '0;
                     sumb_in  = '0;
                  end
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            hash_in  = hash_prod[31:0];
            state_in = ST_HOME;
         end
         ST_HOME: begin
            idx_in   = home_prod[32 +: IDX_W];
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd.valid) begin
               // An empty slot ends the search: a build puts the new key in here.
               if (op_ff == OP_BUILD) begin
                  ram_we  = 1'b1;
                  mult_in = 32'd1;
               end
               state_in = ST_FINISH;
            end else if (rd.key == key_ff) begin
               if (op_ff == OP_BUILD) begin
                  if (rd.count == COUNT_MAX) begin
                     stat_in = STAT_SAT;
                     mult_in = COUNT_MAX;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wdata.count = rd.count + 32'd1;
                     mult_in         = rd.count + 32'd1;
                  end
                  state_in = ST_FINISH;
               end else begin
                  mult_in   = rd.count;
                  mix_start = 1'b1;
                  state_in  = ST_MIX;
               end
            end else if (cnt_ff == LAST_IDX) begin
               // Every slot visited without a hit or a gap: the table is full.
               if (op_ff == OP_BUILD) begin
                  stat_in = STAT_FULL;
               end
               state_in = ST_FINISH;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               idx_in   = idx_next;
               ram_addr = idx_next;
               state_in = ST_CHECK;
            end
         end
         ST_MIX: begin
            if (mix_done) begin
               match_in = match_ff + {32'd0, mult_ff};
               suma_in  = suma_ff + mix_a;
               sumb_in  = sumb_ff + mix_b;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{match_total:  match_ff,
                                checksum_a:   suma_ff,
                                checksum_b:   sumb_ff,
                                multiplicity: mult_ff,
                                status:       stat_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         with_rsp_ff  <= 1'b0;
         match_ff     <= '0;
         suma_ff      <= '0;
         sumb_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         with_rsp_ff  <= with_rsp_in;
         match_ff     <= match_in;
         suma_ff      <= suma_in;
         sumb_ff      <= sumb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      hash_ff     <= hash_in;
      cnt_ff      <= cnt_in;
      mult_ff     <= mult_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The checksum unit only runs while the state machine waits for it.
   a_mix_only_in_mix: assert property (@(posedge clock) disable iff (reset)
      mix_busy |-> state_ff == ST_MIX)
      else $error("checksum unit busy outside the wait state");

   // A build never stores a zero count.
   a_no_zero_count: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == ST_CHECK) |-> ram_wdata.count != 32'd0)
      else $error("zero count written to the table");

   // A new response appears only when the final state hands one over.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready) && !$past(reset))
         |-> $past(state_ff) == ST_FINISH)
      else $error("response loaded outside the final state");

   // Totals move only on a probe hit or a clear of the totals.
   a_totals_stable: assert property (@(posedge clock) disable iff (reset)
      (!mix_done && !(state_ff == ST_IDLE && req_valid &&
                      req_payload.opcode == OP_CLEAR_ALL))
         |=> $stable(match_ff))
      else $error("match total changed unexpectedly");

endmodule

// ===== tb/tb_hash_join_count_probe_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the counting hash-join core.
// Depends on hjc_pkg and hash_join_count_probe_core; drives requests, checks every response.
module tb_hash_join_count_probe_core;
   import hjc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 2200;
   localparam int HOLD_CYCLES    = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   hash_join_count_probe_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // Shadow copy of the table and the running totals.
   bit          shadow_valid [TABLE_DEPTH];
   logic [63:0] shadow_key   [TABLE_DEPTH];
   logic [31:0] shadow_count [TABLE_DEPTH];
   logic [63:0] shadow_matches;
   logic [63:0] shadow_sum_a;
   logic [63:0] shadow_sum_b;

   req_type pending_requests [$];
   rsp_type expected_responses [$];
   int      errors;
   int      sent_count;
   int      rsp_count;
   int      hold_left;
   bit      hold_done;
   int      quiet_cycles;
   logic [63:0] key_pool [16];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] splitmix(input logic [63:0] v);
      logic [63:0] x;
      x = v + GOLDEN64;
      x = (x ^ (x >> 30)) * MIX_C1;
      x = (x ^ (x >> 27)) * MIX_C2;
      return x ^ (x >> 31);
   endfunction

   function automatic int home_of(input logic [63:0] k);
      logic [31:0] h;
      logic [63:0] wide;
      h = (k[31:0] ^ k[63:32]) * GOLDEN32;
      wide = ({32'd0, h} * 64'(TABLE_DEPTH)) >> 32;
      return int'(wide);
   endfunction

   // Linear search: 1 hit, 0 empty slot found, -1 table full.
   function automatic int search_slot(input logic [63:0] k, output int pos);
      int idx;
      idx = home_of(k);
      pos = 0;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         if (!shadow_valid[idx]) begin
            pos = idx;
            return 0;
         end
         if (shadow_key[idx] == k) begin
            pos = idx;
            return 1;
         end
         idx = (idx + 1) % TABLE_DEPTH;
      end
      return -1;
   endfunction

   function automatic rsp_type join_step(input req_type r);
      rsp_type     res;
      int          pos;
      int          found;
      logic [63:0] m;
      res.multiplicity = '0;
      res.status = STAT_OK;
      case (r.opcode)
         OP_BUILD: begin
            found = search_slot(r.join_key, pos);
            if (found == 1) begin
               if (shadow_count[pos] == COUNT_MAX) res.status = STAT_SAT;
               else shadow_count[pos] = shadow_count[pos] + 1;
               res.multiplicity = shadow_count[pos];
            end else if (found == 0) begin
               shadow_valid[pos] = 1'b1;
               shadow_key[pos] = r.join_key;
               shadow_count[pos] = 32'd1;
               res.multiplicity = 32'd1;
            end else begin
               res.status = STAT_FULL;
            end
         end
         OP_PROBE: begin
            found = search_slot(r.join_key, pos);
            if (found == 1) begin
               m = {32'd0, shadow_count[pos]};
               res.multiplicity = shadow_count[pos];
               shadow_matches = shadow_matches + m;
               shadow_sum_a = shadow_sum_a + splitmix(r.join_key) * m;
               shadow_sum_b = shadow_sum_b + splitmix(r.join_key ^ GOLDEN64) * m;
            end
         end
         default: begin
            for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
            if (r.opcode == OP_CLEAR_ALL) begin
               shadow_matches = '0;
               shadow_sum_a = '0;
               shadow_sum_b = '0;
            end
         end
      endcase
      res.match_total = shadow_matches;
      res.checksum_a = shadow_sum_a;
      res.checksum_b = shadow_sum_b;
      return res;
   endfunction

   task automatic add_request(input logic [1:0] op, input logic [63:0] k);
      req_type r;
      r.opcode = op;
      r.join_key = k;
      pending_requests.push_back(r);
   endtask

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Driver: valid stays up with a stable payload until the core takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_responses.push_back(join_step(req_payload));
            sent_count++;
         end
         if (pending_requests.size() != 0 &&
             ((sent_count > 150 && sent_count < 250) || $urandom_range(99) >= 37)) begin
            req_valid <= 1'b1;
            req_payload <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random stalls, one long hold-off so the core backs up,
   // and a field-by-field comparison against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_payload.match_total !== want.match_total) begin
                  $display("%0t: match_total expected %h actual %h",
                           $time, want.match_total, rsp_payload.match_total);
                  errors++;
               end
               if (rsp_payload.checksum_a !== want.checksum_a) begin
                  $display("%0t: checksum_a expected %h actual %h",
                           $time, want.checksum_a, rsp_payload.checksum_a);
                  errors++;
               end
               if (rsp_payload.checksum_b !== want.checksum_b) begin
                  $display("%0t: checksum_b expected %h actual %h",
                           $time, want.checksum_b, rsp_payload.checksum_b);
                  errors++;
               end
               if (rsp_payload.multiplicity !== want.multiplicity) begin
                  $display("%0t: multiplicity expected %h actual %h",
                           $time, want.multiplicity, rsp_payload.multiplicity);
                  errors++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %h actual %h",
                           $time, want.status, rsp_payload.status);
                  errors++;
               end
            end
         end
         if (!hold_done && rsp_count == 250 && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (rsp_count > 150 && rsp_count < 240) ||
                         ($urandom_range(99) >= 37);
         end
      end
   end

   // Watchdog over cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      errors = 0;
      sent_count = 0;
      rsp_count = 0;
      hold_left = 0;
      hold_done = 1'b0;
      quiet_cycles = 0;
      shadow_matches = '0;
      shadow_sum_a = '0;
      shadow_sum_b = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i] = '0;
         shadow_count[i] = '0;
      end
      for (int i = 0; i < 16; i++) key_pool[i] = random_key();
      // Two keys whose halves fold to the same value share a home slot.
      key_pool[1] = {key_pool[0][31:0], key_pool[0][63:32]};
      key_pool[2] = 64'd0;
      key_pool[3] = '1;

      // Directed part: extreme keys, probe misses and hits, a colliding pair,
      // repeated builds and both kinds of clear.
      add_request(OP_PROBE, 64'd0);
      add_request(OP_BUILD, 64'd0);
      add_request(OP_BUILD, '1);
      add_request(OP_BUILD, 64'd0);
      add_request(OP_PROBE, 64'd0);
      add_request(OP_PROBE, '1);
      add_request(OP_BUILD, key_pool[0]);
      add_request(OP_BUILD, key_pool[1]);
      add_request(OP_BUILD, key_pool[1]);
      add_request(OP_PROBE, key_pool[1]);
      add_request(OP_PROBE, key_pool[0]);
      add_request(OP_PROBE, 64'h8000_0000_0000_0000);
      add_request(OP_CLEAR, '1);
      add_request(OP_PROBE, key_pool[0]);
      add_request(OP_BUILD, key_pool[0]);
      add_request(OP_PROBE, key_pool[0]);
      add_request(OP_CLEAR_ALL, 64'd0);
      add_request(OP_PROBE, key_pool[0]);

      // Random part: mostly builds and probes over a small key set so that
      // counts grow and probes hit, with fully random keys and clears mixed in.
      for (int i = 0; i < 380; i++) begin
         r = $urandom_range(99);
         if (r < 40) add_request(OP_BUILD, key_pool[$urandom_range(15)]);
         else if (r < 80) add_request(OP_PROBE, key_pool[$urandom_range(15)]);
         else if (r < 88) add_request(OP_BUILD, random_key());
         else if (r < 96) add_request(OP_PROBE, random_key());
         else if (r < 98) add_request(OP_CLEAR, random_key());
         else add_request(OP_CLEAR_ALL, random_key());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (pending_requests.size() == 0);
      @(posedge clock);
      while (req_valid || expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/hjc_pkg.sv
src/hjc_ram.sv
src/hjc_mix.sv
src/hash_join_count_probe_core.sv
tb/tb_hash_join_count_probe_core.sv
